// ===== rtl/deq_pkg.sv =====
// Package for the double-ended queue: operation and status codes, controller
// states, the command group between controller and datapath, and defaults.
// Depends on nothing.
package deq_pkg;

    localparam int DEFAULT_DEPTH      = 16;
    localparam int DEFAULT_WORD_WIDTH = 32;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } deq_cmd_t;

endpackage

// ===== rtl/deq_ctrl.sv =====
// Controller of the double-ended queue: sequences capture, execution and
// result transfer for one operation at a time. Depends on deq_pkg.
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output deq_pkg::deq_cmd_t cmd
);
    import deq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/deq_datapath.sv =====
// Datapath of the double-ended queue: ring store, front index, entry count
// and result registers, driven by the controller's commands. Depends on deq_pkg.
module deq_datapath #(
    parameter int DEPTH      = deq_pkg::DEFAULT_DEPTH,
    parameter int WORD_WIDTH = deq_pkg::DEFAULT_WORD_WIDTH,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  deq_pkg::deq_cmd_t             cmd,
    input  logic [1:0]                    kind,
    input  logic signed [WORD_WIDTH-1:0]  value,
    output logic signed [WORD_WIDTH-1:0]  popped_value,
    output deq_pkg::status_t              status,
    output logic [CW-1:0]                 entry_count
);
    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = CW + 1;

    logic [WORD_WIDTH-1:0] mem [DEPTH];

    kind_t                 kind_reg;
    logic [WORD_WIDTH-1:0] value_reg;
    logic [AW-1:0]         front_reg;
    logic [AW-1:0]         front_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    status_t               status_reg;
    status_t               status_next;
    logic                  pop_ok_reg;
    logic                  pop_ok_next;
    logic [WORD_WIDTH-1:0] rdata_reg;

    logic                  full;
    logic                  empty;
    logic [SW-1:0]         end_sum;
    logic [SW-1:0]         end_wrap;
    logic [SW-1:0]         last_sum;
    logic [SW-1:0]         last_wrap;
    logic [AW-1:0]         front_dec;
    logic [AW-1:0]         front_inc;
    logic [AW-1:0]         addr;
    logic                  wr_en;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign end_sum   = SW'(front_reg) + SW'(count_reg);
    assign end_wrap  = (end_sum >= SW'(DEPTH)) ? (end_sum - SW'(DEPTH)) : end_sum;
    assign last_sum  = end_sum - SW'(1);
    assign last_wrap = (last_sum >= SW'(DEPTH)) ? (last_sum - SW'(DEPTH)) : last_sum;
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : (front_reg - AW'(1));
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : (front_reg + AW'(1));

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = STATUS_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        addr        = front_reg;
        case (kind_reg)
            KIND_PUSH_FRONT:
            begin
                addr = front_dec;
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_PUSH_BACK:
            begin
                addr = end_wrap[AW-1:0];
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_POP_FRONT:
            begin
                addr = front_reg;
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    pop_ok_next = 1'b1;
                    front_next  = front_inc;
                    count_next  = count_reg - CW'(1);
                end
            end
            KIND_POP_BACK:
            begin
                addr = last_wrap[AW-1:0];
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    pop_ok_next = 1'b1;
                    count_next  = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= kind_t'(kind);
            value_reg <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            if (wr_en)
            begin
                mem[addr] <= value_reg;
            end
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            status_reg <= STATUS_OK;
            pop_ok_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            front_reg  <= front_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    assign popped_value = pop_ok_reg ? rdata_reg : '0;
    assign status       = status_reg;
    assign entry_count  = count_reg;

endmodule

// ===== rtl/double_ended_queue.sv =====
// Double-ended queue of signed words in a ring store of DEPTH entries.
// After an operation is transferred in, the controller steps through its execute
// state and then offers the result in its done state.
// Operations are handled one at a time by the capture, store access and result
// stages of the controller; a stalled result holds the input side.
// Reset clears the front index and entry count; the store contents are left as they are.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEFAULT_DEPTH,
    parameter int WORD_WIDTH = deq_pkg::DEFAULT_WORD_WIDTH,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   kind,
    input  logic signed [WORD_WIDTH-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [WORD_WIDTH-1:0] popped_value,
    output logic [1:0]                   status,
    output logic [CW-1:0]                entry_count
);
    import deq_pkg::*;

    deq_cmd_t cmd;
    status_t  status_int;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .CW         (CW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .kind         (kind),
        .value        (value),
        .popped_value (popped_value),
        .status       (status_int),
        .entry_count  (entry_count)
    );

    assign status = status_int;

endmodule

// ===== test/deq_checker.sv =====
// Transfer monitor and scoreboard for the double-ended queue: tracks the ring
// contents, predicts each result in order and compares every field.
// Depends on deq_pkg for the operation and status codes.
module deq_checker #(
    parameter int DEPTH      = deq_pkg::DEFAULT_DEPTH,
    parameter int WORD_WIDTH = deq_pkg::DEFAULT_WORD_WIDTH,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [1:0]                   kind,
    input  logic signed [WORD_WIDTH-1:0] value,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic signed [WORD_WIDTH-1:0] popped_value,
    input  logic [1:0]                   status,
    input  logic [CW-1:0]                entry_count,
    output int                           fail_count,
    output int                           pending,
    output int                           checked,
    output int                           full_hits,
    output int                           empty_hits,
    output int                           peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] word;
        status_t                      code;
        logic [CW-1:0]                fill;
    } deq_result_t;

    logic signed [WORD_WIDTH-1:0] ring_words [DEPTH];
    int                           head_slot;
    int                           fill;
    deq_result_t                  awaited [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        full_hits  = 0;
        empty_hits = 0;
        peak_fill  = 0;
    end

    function automatic deq_result_t apply_op(kind_t op, logic signed [WORD_WIDTH-1:0] word);
        deq_result_t res;
        res.word = '0;
        res.code = STATUS_OK;
        case (op)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (fill >= DEPTH)
                begin
                    res.code = STATUS_FULL;
                end
                else if (op == KIND_PUSH_FRONT)
                begin
                    head_slot = (head_slot + DEPTH - 1) % DEPTH;
                    ring_words[head_slot] = word;
                    fill++;
                end
                else
                begin
                    ring_words[(head_slot + fill) % DEPTH] = word;
                    fill++;
                end
            end
            default:
            begin
                if (fill == 0)
                begin
                    res.code = STATUS_EMPTY;
                end
                else if (op == KIND_POP_FRONT)
                begin
                    res.word = ring_words[head_slot];
                    head_slot = (head_slot + 1) % DEPTH;
                    fill--;
                end
                else
                begin
                    res.word = ring_words[(head_slot + fill - 1) % DEPTH];
                    fill--;
                end
            end
        endcase
        res.fill = CW'(fill);
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        if (fail_count < 40)
        begin
            $display("%0t ns: result %0d, %s is %0d where %0d was due",
                     $time, checked, field, got, want);
        end
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deq_result_t want;
        if (!rst_n)
        begin
            head_slot = 0;
            fill      = 0;
            awaited.delete();
            pending   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                awaited.push_back(apply_op(kind_t'(kind), value));
                if (fill > peak_fill)
                begin
                    peak_fill = fill;
                end
            end
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    report_mismatch("unexpected result, status", status, -1);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (popped_value !== want.word)
                    begin
                        report_mismatch("popped_value", popped_value, want.word);
                    end
                    if (status !== want.code)
                    begin
                        report_mismatch("status", status, want.code);
                    end
                    if (entry_count !== want.fill)
                    begin
                        report_mismatch("entry_count", entry_count, want.fill);
                    end
                    if (want.code == STATUS_FULL)
                    begin
                        full_hits++;
                    end
                    if (want.code == STATUS_EMPTY)
                    begin
                        empty_hits++;
                    end
                end
                checked++;
            end
            pending = awaited.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Top of the double-ended queue testbench: clock, reset, operation stimulus
// with random idling on both channels, and the verdict.
// Depends on deq_pkg, double_ended_queue and deq_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int DEPTH        = DEFAULT_DEPTH;
    localparam int WORD_WIDTH   = DEFAULT_WORD_WIDTH;
    localparam int CW           = $clog2(DEPTH + 1);
    localparam int RANDOM_OPS   = 1000;
    localparam int CHOKE_CYCLES = 90;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [1:0]                   kind = KIND_PUSH_FRONT;
    logic signed [WORD_WIDTH-1:0] value = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [WORD_WIDTH-1:0] popped_value;
    logic [1:0]                   status;
    logic [CW-1:0]                entry_count;

    int fail_count;
    int pending;
    int checked;
    int full_hits;
    int empty_hits;
    int peak_fill;
    int ops_by_kind [4];
    int sent;
    bit steady;
    bit choke_req;

    always #10 clk = ~clk;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .status       (status),
        .entry_count  (entry_count)
    );

    deq_checker #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .status       (status),
        .entry_count  (entry_count),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .full_hits    (full_hits),
        .empty_hits   (empty_hits),
        .peak_fill    (peak_fill)
    );

    function automatic int idle_cycles();
        int roll;
        if (steady)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    function automatic logic signed [WORD_WIDTH-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return {1'b1, {(WORD_WIDTH - 1){1'b0}}};
            1:       return {1'b0, {(WORD_WIDTH - 1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return WORD_WIDTH'($urandom());
        endcase
    endfunction

    function automatic kind_t pick_kind(int push_share);
        if ($urandom_range(0, 99) < push_share)
        begin
            return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        end
        return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
    endfunction

    task automatic send_op(kind_t op, logic signed [WORD_WIDTH-1:0] word);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        value    <= word;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        ops_by_kind[op]++;
        sent++;
    endtask

    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            int stall;
            if (choke_req)
            begin
                choke_req = 1'b0;
                out_ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = idle_cycles();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int phase;
        int run;
        int push_share;
        sent = 0;
        foreach (ops_by_kind[k])
        begin
            ops_by_kind[k] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(KIND_POP_FRONT, 32'sd7);
        send_op(KIND_POP_BACK, -32'sd7);
        send_op(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
        send_op(KIND_PUSH_BACK, 32'h8000_0000);
        send_op(KIND_POP_BACK, '0);
        send_op(KIND_POP_FRONT, '1);
        send_op(KIND_POP_BACK, '0);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i[0])
            begin
                send_op(KIND_PUSH_BACK, 32'hAAAA_AAAA ^ i);
            end
            else
            begin
                send_op(KIND_PUSH_FRONT, 32'h5555_5555 ^ i);
            end
        end
        send_op(KIND_PUSH_FRONT, '1);
        send_op(KIND_PUSH_BACK, '0);

        phase = 0;
        while (sent < RANDOM_OPS + 25)
        begin
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       push_share = 75;
                1:       push_share = 25;
                default: push_share = 50;
            endcase
            if (phase == 2 || phase == 9)
            begin
                choke_req = 1'b1;
            end
            run = $urandom_range(20, 80);
            repeat (run)
            begin
                send_op(pick_kind(push_share), pick_word());
            end
            phase++;
        end
        steady = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Sent %0d ops: %0d push front, %0d push back, %0d pop front, %0d pop back.",
                 sent, ops_by_kind[KIND_PUSH_FRONT], ops_by_kind[KIND_PUSH_BACK],
                 ops_by_kind[KIND_POP_FRONT], ops_by_kind[KIND_POP_BACK]);
        $display("%0d results checked, %0d refused as full, %0d as empty, peak fill %0d/%0d.",
                 checked, full_hits, empty_hits, peak_fill, DEPTH);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_datapath.sv
rtl/double_ended_queue.sv
test/deq_checker.sv
test/tb.sv
